@@ hw/rtl/atwgd_pkg.sv @@
package atwgd_pkg;

	localparam int ONE_G_DEF = 4096;

	localparam int ACC_W = 16;
	localparam int TIME_W = 48;
	localparam int THR_W = 15;
	localparam int COOL_W = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam int SQ_W = 31;
	localparam int MAG_W = 32;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_TILT_THR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_REL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIFT_THR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN = 3'd3;

	localparam logic [THR_W-1:0] TILT_THR_RST = 15'd1843;
	localparam logic [THR_W-1:0] TILT_REL_RST = 15'd1024;
	localparam logic [THR_W-1:0] LIFT_THR_RST = 15'd1434;
	localparam logic [COOL_W-1:0] COOLDOWN_RST = 24'd1200000;

	typedef enum logic [1:0] {
		GEST_WAKE = 2'd0,
		GEST_NEXT = 2'd1,
		GEST_PREV = 2'd2
	} gesture_t;

	typedef struct packed {
		logic [THR_W-1:0]  tilt_thr;
		logic [THR_W-1:0]  tilt_rel;
		logic [THR_W-1:0]  lift_thr;
		logic [COOL_W-1:0] cooldown;
	} cfg_t;

	typedef struct packed {
		logic              wake;
		logic              tilt_pos;
		logic              tilt_neg;
		logic              tilt_rel;
		logic [TIME_W-1:0] now;
	} feat_t;

	typedef struct packed {
		logic [1:0] n;
		gesture_t   g0;
		logic       l0;
		gesture_t   g1;
	} push_t;

endpackage

@@ hw/rtl/accel_tilt_wake_gesture_detector_unit.sv @@
// Tilt and wake gesture detector for a three-axis accelerometer.
//
// Input channel (in_valid / in_ready): one word per sample, signed x, y, z
// in ONE_G counts per g plus a 48-bit microsecond stamp. A word is taken in
// every cycle while in_ready is high, so the sustained rate is one sample per
// cycle as long as results drain.
// Output channel (out_valid / out_ready): zero, one or two result words per
// sample, wake first, then tilt; last_of_run marks the final word of a sample.
// Path: a sample taken in passes registers s1, s2 and s3 to the cooldown gate,
// and its result words are written into the output queue before they show.
// The three-stage datapath (squares, magnitude compare, cooldown gate) feeds
// the four-word output queue, which drains one word per cycle while out_ready
// is high: a sample with two results occupies two queue slots.
// Stall: when a sample waits at the gate stage and the queue holds fewer than
// two free slots (out_ready low), the whole pipeline holds and in_ready drops.
// Reset: config registers return to their defaults, tilt is armed, the last
// emit stamp is zero and the pipeline and queue are empty.
// Config: cfg_we writes cfg_wdata (masked) to the register named by
// cfg_index; write only while no sample is in flight.
module accel_tilt_wake_gesture_detector_unit
	import atwgd_pkg::*;
#(
	parameter int ONE_G = ONE_G_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [ACC_W-1:0]  accel_x,
	input  logic signed [ACC_W-1:0]  accel_y,
	input  logic signed [ACC_W-1:0]  accel_z,
	input  logic [TIME_W-1:0]        now_us,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               gesture,
	output logic                     last_of_run
);

	cfg_t  cfg_q;
	feat_t feat;
	push_t push;
	logic  feat_valid, space2, adv, fire;

	// config registers, masked to their widths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tilt_thr <= TILT_THR_RST;
			cfg_q.tilt_rel <= TILT_REL_RST;
			cfg_q.lift_thr <= LIFT_THR_RST;
			cfg_q.cooldown <= COOLDOWN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TILT_THR: cfg_q.tilt_thr <= cfg_wdata[THR_W-1:0];
				REG_TILT_REL: cfg_q.tilt_rel <= cfg_wdata[THR_W-1:0];
				REG_LIFT_THR: cfg_q.lift_thr <= cfg_wdata[THR_W-1:0];
				REG_COOLDOWN: cfg_q.cooldown <= cfg_wdata[COOL_W-1:0];
				default: ;
			endcase
		end
	end

	// advance the pipeline unless the gate stage holds a sample and the queue
	// cannot take two words
	assign adv      = !feat_valid || space2;
	assign fire     = feat_valid && adv;
	assign in_ready = adv;

	atwgd_front #(
		.ONE_G (ONE_G)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_take    (in_valid),
		.accel_x    (accel_x),
		.accel_y    (accel_y),
		.accel_z    (accel_z),
		.now_us     (now_us),
		.cfg        (cfg_q),
		.feat_valid (feat_valid),
		.feat       (feat)
	);

	atwgd_gate u_gate (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.feat     (feat),
		.cooldown (cfg_q.cooldown),
		.push     (push)
	);

	atwgd_oq u_oq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (out_valid && out_ready),
		.space2    (space2),
		.not_empty (out_valid),
		.head_g    (gesture),
		.head_l    (last_of_run)
	);

endmodule

@@ hw/rtl/atwgd_front.sv @@
module atwgd_front
	import atwgd_pkg::*;
#(
	parameter int ONE_G = ONE_G_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     in_take,
	input  logic signed [ACC_W-1:0]  accel_x,
	input  logic signed [ACC_W-1:0]  accel_y,
	input  logic signed [ACC_W-1:0]  accel_z,
	input  logic [TIME_W-1:0]        now_us,
	input  cfg_t                     cfg,
	output logic                     feat_valid,
	output feat_t                    feat
);

	localparam int HI_W = $clog2(ONE_G + 32768);
	localparam int HSQ_W = 2 * HI_W;
	localparam int CMP_W = (HSQ_W > MAG_W) ? HSQ_W : MAG_W;

	logic                    v_s1, v_s2, v_s3;
	logic signed [ACC_W-1:0] x_s1, y_s1, z_s1;
	logic [TIME_W-1:0]       now_s1, now_s2, now_s3;
	logic [SQ_W-1:0]         xx_s2, yy_s2, zz_s2;
	logic                    pos_s2, neg_s2, rel_s2;
	logic                    pos_s3, neg_s3, rel_s3, wake_s3;

	logic [HI_W-1:0]  hi_c, lo_c;
	logic [HSQ_W-1:0] hi_sq_q, lo_sq_q;
	logic             lo_pos_q;

	logic signed [31:0]      xx_c, yy_c, zz_c;
	logic signed [ACC_W:0]   sx_c, thr_c;
	logic [ACC_W:0]          ax_c;
	logic [MAG_W-1:0]        mag_c;
	logic [CMP_W-1:0]        mag_x, hi_x, lo_x;

	// thresholds squared, refreshed from the config registers every cycle
	assign hi_c = HI_W'(ONE_G) + HI_W'(cfg.lift_thr);
	assign lo_c = HI_W'(ONE_G) - HI_W'(cfg.lift_thr);

	always_ff @(posedge clk) begin
		hi_sq_q  <= HSQ_W'(hi_c) * HSQ_W'(hi_c);
		lo_sq_q  <= HSQ_W'(lo_c) * HSQ_W'(lo_c);
		lo_pos_q <= HI_W'(cfg.lift_thr) < HI_W'(ONE_G);
	end

	assign xx_c  = 32'(x_s1) * 32'(x_s1);
	assign yy_c  = 32'(y_s1) * 32'(y_s1);
	assign zz_c  = 32'(z_s1) * 32'(z_s1);
	assign sx_c  = {x_s1[ACC_W-1], x_s1};
	assign thr_c = $signed({2'b00, cfg.tilt_thr});
	assign ax_c  = x_s1[ACC_W-1] ? (ACC_W+1)'(-sx_c) : (ACC_W+1)'(sx_c);

	assign mag_c = MAG_W'(xx_s2) + MAG_W'(yy_s2) + MAG_W'(zz_s2);
	assign mag_x = CMP_W'(mag_c);
	assign hi_x  = CMP_W'(hi_sq_q);
	assign lo_x  = CMP_W'(lo_sq_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= accel_x;
			y_s1    <= accel_y;
			z_s1    <= accel_z;
			now_s1  <= now_us;
			xx_s2   <= xx_c[SQ_W-1:0];
			yy_s2   <= yy_c[SQ_W-1:0];
			zz_s2   <= zz_c[SQ_W-1:0];
			pos_s2  <= sx_c > thr_c;
			neg_s2  <= sx_c < -thr_c;
			rel_s2  <= ax_c < {2'b00, cfg.tilt_rel};
			now_s2  <= now_s1;
			wake_s3 <= (mag_x > hi_x) || (lo_pos_q && (mag_x < lo_x));
			pos_s3  <= pos_s2;
			neg_s3  <= neg_s2;
			rel_s3  <= rel_s2;
			now_s3  <= now_s2;
		end
	end

	assign feat_valid    = v_s3;
	assign feat.wake     = wake_s3;
	assign feat.tilt_pos = pos_s3;
	assign feat.tilt_neg = neg_s3;
	assign feat.tilt_rel = rel_s3;
	assign feat.now      = now_s3;

endmodule

@@ hw/rtl/atwgd_gate.sv @@
module atwgd_gate
	import atwgd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  feat_t             feat,
	input  logic [COOL_W-1:0] cooldown,
	output push_t             push
);

	logic              armed_q;
	logic [TIME_W-1:0] last_q;

	logic [TIME_W:0] diff_c;
	logic            diff_ok, wake_emit, tilt_hit, tilt_ok, tilt_emit;
	gesture_t        tilt_g;

	// signed difference of two 48-bit stamps fits in 49 bits
	assign diff_c    = {1'b0, feat.now} - {1'b0, last_q};
	assign diff_ok   = !diff_c[TIME_W] && (diff_c[TIME_W-1:0] >= TIME_W'(cooldown));
	assign wake_emit = feat.wake && diff_ok;
	assign tilt_hit  = armed_q && (feat.tilt_pos || feat.tilt_neg);
	assign tilt_g    = feat.tilt_pos ? GEST_NEXT : GEST_PREV;
	// a wake emit just moved the stamp to now, so the gap is zero
	assign tilt_ok   = wake_emit ? (cooldown == '0) : diff_ok;
	assign tilt_emit = tilt_hit && tilt_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b1;
			last_q  <= '0;
		end else if (fire) begin
			if (wake_emit || tilt_emit) begin
				last_q <= feat.now;
			end
			if (tilt_hit) begin
				armed_q <= 1'b0;
			end else if (!armed_q && feat.tilt_rel) begin
				armed_q <= 1'b1;
			end
		end
	end

	always_comb begin
		push.n  = fire ? ({1'b0, wake_emit} + {1'b0, tilt_emit}) : 2'd0;
		push.g0 = wake_emit ? GEST_WAKE : tilt_g;
		push.l0 = !(wake_emit && tilt_emit);
		push.g1 = tilt_g;
	end

endmodule

@@ hw/rtl/atwgd_oq.sv @@
module atwgd_oq
	import atwgd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  push_t      push,
	input  logic       pop,
	output logic       space2,
	output logic       not_empty,
	output logic [1:0] head_g,
	output logic       head_l
);

	logic [2:0]          mem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wp_q, rp_q;
	logic [OQ_CNT_W-1:0] cnt_q;
	logic [OQ_PTR_W-1:0] wp1;

	assign wp1 = wp_q + OQ_PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wp_q] <= {push.g0, push.l0};
		end
		if (push.n == 2'd2) begin
			mem_q[wp1] <= {push.g1, 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + OQ_PTR_W'(push.n);
			rp_q  <= rp_q + OQ_PTR_W'(pop);
			cnt_q <= cnt_q + OQ_CNT_W'(push.n) - OQ_CNT_W'(pop);
		end
	end

	assign space2    = cnt_q <= OQ_CNT_W'(OQ_DEPTH - 2);
	assign not_empty = cnt_q != '0;
	assign head_g    = mem_q[rp_q][2:1];
	assign head_l    = mem_q[rp_q][0];

endmodule
